// File: hw/rtl/delimited_length_frame_parser_assert.svh
// Assertion macros for the delimited length frame parser.
// Included by the top level; no other dependencies.
`ifndef DELIMITED_LENGTH_FRAME_PARSER_ASSERT_SVH
`define DELIMITED_LENGTH_FRAME_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define DLFP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define DLFP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DLFP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DLFP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hw/rtl/dlfp_pkg.sv
// Shared types and constants of the delimited length frame parser.
// No dependencies; used by dlfp_cfg, dlfp_core and the top level.
package dlfp_pkg;

    // Default sizing limits
    localparam int MAX_HEADER_BYTES_DEF = 16;
    localparam int MAX_CHECK_BYTES_DEF  = 8;

    // Configuration register indexes
    localparam logic [2:0] REG_DELIMITER    = 3'd0;
    localparam logic [2:0] REG_HEADER_SIZE  = 3'd1;
    localparam logic [2:0] REG_LENGTH_OFS   = 3'd2;
    localparam logic [2:0] REG_LENGTH_WIDTH = 3'd3;
    localparam logic [2:0] REG_CHECK_SIZE   = 3'd4;
    localparam logic [2:0] REG_MAX_PAYLOAD  = 3'd5;

    // Length field width codes
    localparam logic [1:0] LW_ONE = 2'd0;
    localparam logic [1:0] LW_TWO = 2'd1;

    // Section tags
    localparam logic [1:0] SEC_DELIM   = 2'd0;
    localparam logic [1:0] SEC_HEADER  = 2'd1;
    localparam logic [1:0] SEC_PAYLOAD = 2'd2;
    localparam logic [1:0] SEC_CHECK   = 2'd3;

    // Register reset values
    localparam logic [7:0]  DELIMITER_RST    = 8'd0;
    localparam logic [4:0]  HEADER_SIZE_RST  = 5'd4;
    localparam logic [3:0]  LENGTH_OFS_RST   = 4'd0;
    localparam logic [1:0]  LENGTH_WIDTH_RST = 2'd0;
    localparam logic [3:0]  CHECK_SIZE_RST   = 4'd2;
    localparam logic [31:0] MAX_PAYLOAD_RST  = 32'd1024;

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_HEADER,
        MODE_PAYLOAD,
        MODE_CHECK
    } mode_t;

    typedef struct packed {
        logic [7:0]  delimiter;
        logic [4:0]  header_size;
        logic [3:0]  length_offset;
        logic [1:0]  length_width;
        logic [3:0]  check_size;
        logic [31:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  section;
        logic        frame_last;
        logic        frame_dropped;
        logic [31:0] payload_length;
    } result_t;

endpackage

// File: hw/rtl/dlfp_cfg.sv
// Configuration register file of the delimited length frame parser.
// Depends on dlfp_pkg for register indexes, reset values and cfg_t.
module dlfp_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output dlfp_pkg::cfg_t    cfg
);

    dlfp_pkg::cfg_t cfg_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter     <= dlfp_pkg::DELIMITER_RST;
            cfg_reg.header_size   <= dlfp_pkg::HEADER_SIZE_RST;
            cfg_reg.length_offset <= dlfp_pkg::LENGTH_OFS_RST;
            cfg_reg.length_width  <= dlfp_pkg::LENGTH_WIDTH_RST;
            cfg_reg.check_size    <= dlfp_pkg::CHECK_SIZE_RST;
            cfg_reg.max_payload   <= dlfp_pkg::MAX_PAYLOAD_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dlfp_pkg::REG_DELIMITER:    cfg_reg.delimiter     <= cfg_data[7:0];
                dlfp_pkg::REG_HEADER_SIZE:  cfg_reg.header_size   <= cfg_data[4:0];
                dlfp_pkg::REG_LENGTH_OFS:   cfg_reg.length_offset <= cfg_data[3:0];
                dlfp_pkg::REG_LENGTH_WIDTH: cfg_reg.length_width  <= cfg_data[1:0];
                dlfp_pkg::REG_CHECK_SIZE:   cfg_reg.check_size    <= cfg_data[3:0];
                dlfp_pkg::REG_MAX_PAYLOAD:  cfg_reg.max_payload   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/dlfp_core.sv
// Parser core: input register, frame state update, result register.
// Depends on dlfp_pkg for mode_t, cfg_t, result_t and section tags.
module dlfp_core #(
    parameter int MAX_HEADER_BYTES = dlfp_pkg::MAX_HEADER_BYTES_DEF,
    parameter int MAX_CHECK_BYTES  = dlfp_pkg::MAX_CHECK_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dlfp_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output dlfp_pkg::result_t out_res
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Frame state
    dlfp_pkg::mode_t mode_reg, mode_next;
    logic [31:0]     pos_reg, pos_next;
    logic [31:0]     len_reg, len_next;

    // Result register
    logic              out_valid_reg;
    dlfp_pkg::result_t res_reg;

    // Combinational result
    logic              res_valid;
    dlfp_pkg::result_t res;

    logic        out_free;
    logic        consume;
    logic [31:0] hdr_eff;
    logic [31:0] chk_eff;
    logic [2:0]  width_eff;
    logic [31:0] pos_inc;
    logic [31:0] off_ext;
    logic [31:0] diff;
    logic        capture;
    logic [31:0] shifted;
    logic [31:0] len_hdr;
    logic        hdr_done;
    logic        excess_cur;
    logic        excess_hdr;
    logic [33:0] chk_sum;
    logic        is_delim;

    // Handshake: the item in the input register moves on when the result slot is free
    assign out_free  = !out_valid_reg || out_ready;
    assign consume   = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || out_free;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    // Effective sizes with saturation
    always_comb
    begin
        hdr_eff = {27'd0, cfg.header_size};
        if (hdr_eff == 32'd0)
        begin
            hdr_eff = 32'd1;
        end
        if (hdr_eff > 32'(MAX_HEADER_BYTES))
        begin
            hdr_eff = 32'(MAX_HEADER_BYTES);
        end
        chk_eff = {28'd0, cfg.check_size};
        if (chk_eff > 32'(MAX_CHECK_BYTES))
        begin
            chk_eff = 32'(MAX_CHECK_BYTES);
        end
        case (cfg.length_width)
            dlfp_pkg::LW_ONE: width_eff = 3'd1;
            dlfp_pkg::LW_TWO: width_eff = 3'd2;
            default:          width_eff = 3'd4;
        endcase
    end

    // Length field capture and section-end tests
    assign pos_inc    = pos_reg + 32'd1;
    assign off_ext    = {28'd0, cfg.length_offset};
    assign diff       = pos_reg - off_ext;
    assign capture    = (pos_reg >= off_ext) && (diff < {29'd0, width_eff})
                        && (pos_reg < hdr_eff);
    assign shifted    = {24'd0, in_byte_reg} << {diff[1:0], 3'b000};
    assign len_hdr    = len_reg | (capture ? shifted : 32'd0);
    assign hdr_done   = pos_inc >= hdr_eff;
    assign excess_cur = len_reg > cfg.max_payload;
    assign excess_hdr = len_hdr > cfg.max_payload;
    assign chk_sum    = {2'b00, len_reg} + {2'b00, pos_inc};
    assign is_delim   = in_byte_reg == cfg.delimiter;

    // Next frame state
    always_comb
    begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        len_next  = len_reg;
        if (consume)
        begin
            case (mode_reg)
                dlfp_pkg::MODE_HEADER:
                begin
                    len_next = len_hdr;
                    pos_next = pos_inc;
                    if (hdr_done)
                    begin
                        pos_next = 32'd0;
                        if (chk_eff == 32'd0 && (excess_hdr || len_hdr == 32'd0))
                        begin
                            mode_next = dlfp_pkg::MODE_HUNT;
                        end
                        else if (len_hdr == 32'd0)
                        begin
                            mode_next = dlfp_pkg::MODE_CHECK;
                        end
                        else
                        begin
                            mode_next = dlfp_pkg::MODE_PAYLOAD;
                        end
                    end
                end
                dlfp_pkg::MODE_PAYLOAD:
                begin
                    pos_next = pos_inc;
                    if (excess_cur && pos_inc == chk_eff)
                    begin
                        mode_next = dlfp_pkg::MODE_HUNT;
                        pos_next  = 32'd0;
                    end
                    else if (pos_inc >= len_reg)
                    begin
                        pos_next  = 32'd0;
                        mode_next = (chk_eff == 32'd0) ? dlfp_pkg::MODE_HUNT
                                                       : dlfp_pkg::MODE_CHECK;
                    end
                end
                dlfp_pkg::MODE_CHECK:
                begin
                    pos_next = pos_inc;
                    if ((excess_cur && chk_sum == {2'b00, chk_eff}) || pos_inc >= chk_eff)
                    begin
                        mode_next = dlfp_pkg::MODE_HUNT;
                        pos_next  = 32'd0;
                    end
                end
                default:
                begin
                    if (is_delim)
                    begin
                        mode_next = dlfp_pkg::MODE_HEADER;
                        pos_next  = 32'd0;
                        len_next  = 32'd0;
                    end
                end
            endcase
        end
    end

    // Result for the item being consumed
    always_comb
    begin
        res_valid          = 1'b1;
        res.out_byte       = in_byte_reg;
        res.section        = dlfp_pkg::SEC_DELIM;
        res.frame_last     = 1'b0;
        res.frame_dropped  = 1'b0;
        res.payload_length = 32'd0;
        case (mode_reg)
            dlfp_pkg::MODE_HEADER:
            begin
                res.section = dlfp_pkg::SEC_HEADER;
                if (hdr_done)
                begin
                    res.payload_length = len_hdr;
                    res.frame_dropped  = (chk_eff == 32'd0) && excess_hdr;
                    res.frame_last     = (chk_eff == 32'd0) && !excess_hdr
                                         && (len_hdr == 32'd0);
                end
            end
            dlfp_pkg::MODE_PAYLOAD:
            begin
                res.section        = dlfp_pkg::SEC_PAYLOAD;
                res.payload_length = len_reg;
                if (excess_cur && pos_inc == chk_eff)
                begin
                    res.frame_dropped = 1'b1;
                end
                else if (pos_inc >= len_reg && chk_eff == 32'd0)
                begin
                    res.frame_last = 1'b1;
                end
            end
            dlfp_pkg::MODE_CHECK:
            begin
                res.section        = dlfp_pkg::SEC_CHECK;
                res.payload_length = len_reg;
                if (excess_cur && chk_sum == {2'b00, chk_eff})
                begin
                    res.frame_dropped = 1'b1;
                end
                else if (pos_inc >= chk_eff)
                begin
                    res.frame_last = 1'b1;
                end
            end
            default:
            begin
                res_valid = is_delim;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= dlfp_pkg::MODE_HUNT;
            pos_reg       <= 32'd0;
            len_reg       <= 32'd0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= consume && res_valid;
            end
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            len_reg  <= len_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
        end
        if (consume && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

// File: hw/rtl/delimited_length_frame_parser.sv
// Top level of the delimited length frame parser: stream ports and config port.
// Depends on dlfp_pkg, dlfp_cfg, dlfp_core and the assertion macro header.
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid / s_tready  tdata: rx_byte
//   m_*       out        m_tvalid / m_tready  tdata, tuser, tlast (see ports)
//   cfg_*     in         cfg_valid / cfg_ready index + 32-bit data
//
// One byte per cycle sustained while m_tready is high; a byte taken on s_* passes
// through the input register, then the result register, before it reaches m_*.
// Bytes discarded while hunting produce no output item.
// Reset clears the frame state to hunting and the registers to their defaults.
// A stall on m_tready holds the result, then fills the input register and drops s_tready.
module delimited_length_frame_parser #(
    parameter int MAX_HEADER_BYTES = dlfp_pkg::MAX_HEADER_BYTES_DEF,
    parameter int MAX_CHECK_BYTES  = dlfp_pkg::MAX_CHECK_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [7:0] out_byte, [39:8] payload_length
    output logic [2:0]  m_tuser,    // [1:0] section, [2] frame_dropped
    output logic        m_tlast,    // frame_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

`include "delimited_length_frame_parser_assert.svh"

    dlfp_pkg::cfg_t    cfg;
    dlfp_pkg::result_t res;

    dlfp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dlfp_core #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES),
        .MAX_CHECK_BYTES  (MAX_CHECK_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Output packing
    assign m_tdata = {res.payload_length, res.out_byte};
    assign m_tuser = {res.frame_dropped, res.section};
    assign m_tlast = res.frame_last;

    // A frame is either completed or dropped, never both on one item
    `DLFP_ASSERT_IMP(a_last_xor_drop, clk, rst_n, m_tvalid, !(m_tlast && m_tuser[2]), "last and dropped together")
    // The delimiter never ends or drops a frame
    `DLFP_ASSERT_IMP(a_delim_flags, clk, rst_n, m_tvalid && m_tuser[1:0] == dlfp_pkg::SEC_DELIM, !m_tlast && !m_tuser[2], "flag on delimiter")
    // The delimiter carries no decoded length
    `DLFP_ASSERT_IMP(a_delim_len, clk, rst_n, m_tvalid && m_tuser[1:0] == dlfp_pkg::SEC_DELIM, m_tdata[39:8] == 32'd0, "length on delimiter")

endmodule

// File: bench/tb_delimited_length_frame_parser.sv
// Self-checking bench for the delimited length frame parser: random byte streams of
// well-formed, cut and noisy frames under random stalls. Depends on dlfp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_delimited_length_frame_parser;
    import dlfp_pkg::*;

    // Indexes with no register behind them; writes there are ignored
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam int ITEM_TARGET  = 1600;

    // Tracks parser state and holds the bytes the parser should forward, oldest first
    class frame_scoreboard;
        cfg_t        cfg;
        mode_t       mode;
        logic [31:0] pos;
        logic [31:0] len_acc;
        result_t     fwd_q[$];
        int          errors;

        function new();
            cfg.delimiter     = DELIMITER_RST;
            cfg.header_size   = HEADER_SIZE_RST;
            cfg.length_offset = LENGTH_OFS_RST;
            cfg.length_width  = LENGTH_WIDTH_RST;
            cfg.check_size    = CHECK_SIZE_RST;
            cfg.max_payload   = MAX_PAYLOAD_RST;
            mode    = MODE_HUNT;
            pos     = '0;
            len_acc = '0;
            errors  = 0;
        endfunction

        function int unsigned hdr_bytes();
            int unsigned h;
            h = (cfg.header_size == 0) ? 1 : cfg.header_size;
            if (h > MAX_HEADER_BYTES_DEF) h = MAX_HEADER_BYTES_DEF;
            return h;
        endfunction

        function int unsigned chk_bytes();
            return (cfg.check_size > MAX_CHECK_BYTES_DEF) ? MAX_CHECK_BYTES_DEF
                                                          : cfg.check_size;
        endfunction

        function int unsigned len_bytes();
            case (cfg.length_width)
                LW_ONE:  return 1;
                LW_TWO:  return 2;
                default: return 4;
            endcase
        endfunction

        // Length value the parser will see, given only header bytes count
        function logic [31:0] visible_length(logic [31:0] v);
            logic [31:0] m;
            int unsigned k;
            m = '0;
            for (k = 0; k < len_bytes(); k++)
                if (cfg.length_offset + k < hdr_bytes()) m[8*k +: 8] = 8'hFF;
            return v & m;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_DELIMITER:    cfg.delimiter     = data[7:0];
                REG_HEADER_SIZE:  cfg.header_size   = data[4:0];
                REG_LENGTH_OFS:   cfg.length_offset = data[3:0];
                REG_LENGTH_WIDTH: cfg.length_width  = data[1:0];
                REG_CHECK_SIZE:   cfg.check_size    = data[3:0];
                REG_MAX_PAYLOAD:  cfg.max_payload   = data;
                default: ;
            endcase
        endfunction

        function bit hunting();
            return mode == MODE_HUNT;
        endfunction

        function int pending();
            return fwd_q.size();
        endfunction

        // Advance the frame state by one received byte
        function void note_rx(logic [7:0] b);
            int unsigned hdr, chk, w, i, ofs;
            bit excess;
            result_t r;
            hdr = hdr_bytes();
            chk = chk_bytes();
            w   = len_bytes();
            ofs = cfg.length_offset;
            excess = len_acc > cfg.max_payload;
            r = '0;
            r.out_byte = b;
            case (mode)
                MODE_HEADER:
                begin
                    i = pos;
                    if (i >= ofs && i - ofs < w && i < hdr)
                        len_acc = len_acc | ({24'd0, b} << (8 * (i - ofs)));
                    pos++;
                    r.section = SEC_HEADER;
                    if (pos >= hdr)
                    begin
                        excess = len_acc > cfg.max_payload;
                        r.payload_length = len_acc;
                        pos = '0;
                        if (chk == 0 && excess)
                        begin
                            r.frame_dropped = 1'b1;
                            mode = MODE_HUNT;
                        end
                        else if (len_acc == 0 && chk == 0)
                        begin
                            r.frame_last = 1'b1;
                            mode = MODE_HUNT;
                        end
                        else if (len_acc == 0)
                        begin
                            mode = MODE_CHECK;
                        end
                        else
                        begin
                            mode = MODE_PAYLOAD;
                        end
                    end
                end
                MODE_PAYLOAD:
                begin
                    pos++;
                    r.section = SEC_PAYLOAD;
                    r.payload_length = len_acc;
                    if (excess && pos == chk)
                    begin
                        r.frame_dropped = 1'b1;
                        mode = MODE_HUNT;
                        pos = '0;
                    end
                    else if (pos >= len_acc)
                    begin
                        pos = '0;
                        if (chk == 0)
                        begin
                            r.frame_last = 1'b1;
                            mode = MODE_HUNT;
                        end
                        else
                        begin
                            mode = MODE_CHECK;
                        end
                    end
                end
                MODE_CHECK:
                begin
                    pos++;
                    r.section = SEC_CHECK;
                    r.payload_length = len_acc;
                    if (excess && 64'(len_acc) + 64'(pos) == 64'(chk))
                    begin
                        r.frame_dropped = 1'b1;
                        mode = MODE_HUNT;
                        pos = '0;
                    end
                    else if (pos >= chk)
                    begin
                        r.frame_last = 1'b1;
                        mode = MODE_HUNT;
                        pos = '0;
                    end
                end
                default:
                begin
                    // Bytes other than the delimiter are discarded while hunting
                    if (b != cfg.delimiter) return;
                    mode = MODE_HEADER;
                    pos = '0;
                    len_acc = '0;
                    r.section = SEC_DELIM;
                end
            endcase
            fwd_q.push_back(r);
        endfunction

        function void report(string what, logic [31:0] exp_v, logic [31:0] got_v);
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, got_v);
        endfunction

        function void check_item(result_t got);
            result_t exp_r;
            if (fwd_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item, expected none, actual %h", $time, got);
                return;
            end
            exp_r = fwd_q.pop_front();
            if (got.out_byte != exp_r.out_byte)
                report("out_byte", 32'(exp_r.out_byte), 32'(got.out_byte));
            if (got.section != exp_r.section)
                report("section", 32'(exp_r.section), 32'(got.section));
            if (got.frame_last != exp_r.frame_last)
                report("frame_last", 32'(exp_r.frame_last), 32'(got.frame_last));
            if (got.frame_dropped != exp_r.frame_dropped)
                report("frame_dropped", 32'(exp_r.frame_dropped), 32'(got.frame_dropped));
            if (got.payload_length != exp_r.payload_length)
                report("payload_length", exp_r.payload_length, got.payload_length);
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    frame_scoreboard sb;
    bit          tx_fast;
    bit          rx_fast;
    int          tx_count;
    int unsigned stall_left;
    int unsigned rx_hold;

    delimited_length_frame_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side: check each accepted item, then stall for a random number of cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                sb.check_item('{out_byte: m_tdata[7:0], section: m_tuser[1:0],
                                frame_last: m_tlast, frame_dropped: m_tuser[2],
                                payload_length: m_tdata[39:8]});
                rx_hold = rx_fast ? 0 : $urandom_range(0, 19);
                if (rx_hold > 0)
                begin
                    stall_left = rx_hold;
                    m_tready <= 1'b0;
                end
            end
            else if (!m_tready)
            begin
                if (stall_left > 1)
                begin
                    stall_left--;
                end
                else
                begin
                    stall_left = 0;
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Input side: one byte per call, random gap in front
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = tx_fast ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_rx(b);
        tx_count++;
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Wait until every forwarded byte has arrived, then let the pipeline empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Program all registers; unused upper data bits carry junk
    task automatic apply_setup(input logic [7:0] delim, input logic [4:0] hs,
                               input logic [3:0] ofs, input logic [1:0] wc,
                               input logic [3:0] cs, input logic [31:0] mp);
        logic [31:0] junk;
        junk = $urandom();
        cfg_write(REG_DELIMITER,    {junk[31:8], delim});
        cfg_write(REG_HEADER_SIZE,  {junk[26:0], hs});
        cfg_write(REG_LENGTH_OFS,   {junk[27:0], ofs});
        cfg_write(REG_LENGTH_WIDTH, {junk[29:0], wc});
        cfg_write(REG_CHECK_SIZE,   {junk[31:4], cs});
        cfg_write(REG_MAX_PAYLOAD,  mp);
        if ($urandom_range(0, 3) == 0)
            cfg_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
        cfg_valid <= 1'b0;
    endtask

    // Payload length to encode; never a long accepted payload
    function automatic logic [31:0] pick_length();
        logic [31:0] v;
        logic [31:0] seen;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)      v = '0;
        else if (r < 65) v = $urandom_range(1, 6);
        else if (r < 80) v = $urandom_range(7, 40);
        else if (r < 90) v = sb.cfg.max_payload + 1;
        else             v = $urandom();
        seen = sb.visible_length(v);
        if (seen <= sb.cfg.max_payload && seen > 300) v = $urandom_range(0, 6);
        return v;
    endfunction

    // Random bytes until the parser is hunting again
    task automatic finish_frame();
        while (!sb.hunting()) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Delimiter plus header with the length field; cut > 0 stops after that many bytes
    task automatic send_frame(input logic [31:0] len, input int unsigned cut);
        logic [7:0]  hb [MAX_HEADER_BYTES_DEF];
        int unsigned hdr, k;
        hdr = sb.hdr_bytes();
        for (k = 0; k < hdr; k++) hb[k] = 8'($urandom_range(0, 255));
        for (k = 0; k < sb.len_bytes(); k++)
            if (sb.cfg.length_offset + k < hdr) hb[sb.cfg.length_offset + k] = len[8*k +: 8];
        send_byte(sb.cfg.delimiter);
        for (k = 0; k < hdr; k++)
        begin
            if (cut != 0 && k + 1 >= cut) return;
            send_byte(hb[k]);
        end
        finish_frame();
    endtask

    // Noise between frames; a delimiter-valued byte only where lengths stay bounded
    task automatic send_noise(input bit safe);
        int unsigned n, k;
        logic [7:0]  b;
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
        begin
            b = 8'($urandom_range(0, 255));
            while (!safe && b == sb.cfg.delimiter) b = 8'($urandom_range(0, 255));
            send_byte(b);
            finish_frame();
        end
    endtask

    task automatic run_phase(input logic [7:0] delim, input logic [4:0] hs,
                             input logic [3:0] ofs, input logic [1:0] wc,
                             input logic [3:0] cs, input logic [31:0] mp,
                             input int unsigned frames);
        int unsigned f, r;
        bit safe;
        drain();
        apply_setup(delim, hs, ofs, wc, cs, mp);
        safe = mp <= 300;
        for (f = 0; f < frames; f++)
        begin
            tx_fast = $urandom_range(0, 3) == 0;
            rx_fast = $urandom_range(0, 3) == 0;
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                send_frame(pick_length(), 0);
            end
            else if (r < 85)
            begin
                send_noise(safe);
            end
            else if (safe)
            begin
                // Frame cut short and overrun by the next one
                send_frame(pick_length(), $urandom_range(1, sb.hdr_bytes()));
                send_frame(pick_length(), 0);
            end
            else
            begin
                send_frame(pick_length(), 0);
            end
            if ($urandom_range(0, 29) == 0) drain();
        end
    endtask

    // Hard stop if the run hangs
    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [7:0]  dir_bytes [$];
        logic [31:0] mp;
        logic [4:0]  hs;
        logic [3:0]  cs;
        dir_bytes = '{8'h5A, 8'h00, 8'h03, 8'hFF, 8'h80, 8'h01, 8'hAB, 8'h00, 8'hFF,
                      8'h7E, 8'h81, 8'hC3, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'hC3,
                      8'h3C, 8'hFF};
        sb = new();
        tx_count = 0;
        stall_left = 0;
        tx_fast = 1'b0;
        rx_fast = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: a three-byte frame, a zero-length frame, noise around them
        foreach (dir_bytes[k]) send_byte(dir_bytes[k]);

        // Extreme settings
        run_phase(8'hFF, 5'd0,  4'd0,  2'd0, 4'd0,  32'd0,          12);
        run_phase(8'h00, 5'd31, 4'd15, 2'd3, 4'd15, 32'hFFFF_FFFF,  8);
        run_phase(8'hA5, 5'd16, 4'd12, 2'd2, 4'd8,  32'd1024,       10);
        run_phase(8'h3C, 5'd1,  4'd0,  2'd1, 4'd1,  32'd5,          12);
        run_phase(8'h7E, 5'd4,  4'd2,  2'd1, 4'd0,  32'd20,         12);

        // Random settings until enough bytes went in
        while (tx_count < ITEM_TARGET)
        begin
            hs = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(1, 6))
                                            : 5'($urandom_range(0, 31));
            cs = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3))
                                            : 4'($urandom_range(0, 15));
            case ($urandom_range(0, 5))
                0:       mp = '0;
                1:       mp = $urandom_range(1, 20);
                2:       mp = 32'd1024;
                3:       mp = 32'd300;
                4:       mp = $urandom();
                default: mp = 32'hFFFF_FFFF;
            endcase
            run_phase(8'($urandom_range(0, 255)), hs, 4'($urandom_range(0, 15)),
                      2'($urandom_range(0, 3)), cs, mp, $urandom_range(8, 20));
        end
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
